// ----- rtl/idlr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idlr_pkg: shared types and constants of the date line reformatter
// Character codes, line limits, the line record passed from front to back,
// and small calendar helpers.
// ----------------------------------------------------------------------------
package idlr_pkg;

    localparam int LINE_CAPACITY = 64;

    localparam int KEPT_CHARS = 11;
    localparam int KEPT_IDX_W = 4;
    localparam int LEN_W      = 7;
    localparam int CMP_W      = 11;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_DASH  = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    localparam logic [3:0] POS_LAST = 4'd9;

    // One closed line as the back end needs it: a verdict and eight digits.
    typedef struct packed {
        logic       ok;
        logic [3:0] d1;
        logic [3:0] d0;
        logic [3:0] m1;
        logic [3:0] m0;
        logic [3:0] y3;
        logic [3:0] y2;
        logic [3:0] y1;
        logic [3:0] y0;
    } line_rec_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Two decimal digits form a multiple of four.
    function automatic logic div4(input logic [3:0] tens, input logic [3:0] ones);
        if (tens[0] == 1'b0) begin
            return (ones == 4'd0) || (ones == 4'd4) || (ones == 4'd8);
        end
        return (ones == 4'd2) || (ones == 4'd6);
    endfunction

    function automatic logic [6:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
        return {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
    endfunction

    function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
        logic [4:0] dim;
        case (month)
            7'd2:                           dim = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:        dim = 5'd30;
            default:                        dim = 5'd31;
        endcase
        return dim;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/idlr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idlr_front: line collector and classifier
// Keeps the first characters of the current line, closes it on newline or
// end of input, and pushes one checked line record per closed line.
// ----------------------------------------------------------------------------
module idlr_front import idlr_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_input,
    output logic            push,
    output line_rec_t       rec
);

    logic [7:0]       chars_reg [KEPT_CHARS];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;

    logic             close_line;
    logic             wr_en;
    logic [CMP_W-1:0] len_plus;
    logic             shape_ok;
    logic             digits_ok;
    logic             leap;
    logic [6:0]       month;
    logic [6:0]       day;
    logic [4:0]       dim;
    logic             zero_year;
    logic             low_zero;

    assign close_line = end_of_input ? ((len_reg != '0) || ovf_reg) : (char_code == CHAR_NL);
    assign len_plus   = CMP_W'(len_reg) + CMP_W'(1);

    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        wr_en    = 1'b0;
        if (in_fire) begin
            if (close_line) begin
                len_next = '0;
                ovf_next = 1'b0;
            end else if (!end_of_input && !ovf_reg) begin
                if (len_plus >= CMP_W'(LINE_CAPACITY)) begin
                    ovf_next = 1'b1;
                end else begin
                    wr_en = (len_reg < LEN_W'(KEPT_CHARS));
                    if (len_reg != LEN_MAX) begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            chars_reg[len_reg[KEPT_IDX_W-1:0]] <= char_code;
        end
    end

    // A ten-character line, or eleven with a trailing carriage return.
    assign shape_ok = !ovf_reg
                   && (((len_reg == LEN_W'(10)) && (chars_reg[9] != CHAR_CR))
                    || ((len_reg == LEN_W'(11)) && (chars_reg[10] == CHAR_CR)))
                   && (chars_reg[4] == CHAR_DASH) && (chars_reg[7] == CHAR_DASH);

    assign digits_ok = is_digit(chars_reg[0]) && is_digit(chars_reg[1])
                    && is_digit(chars_reg[2]) && is_digit(chars_reg[3])
                    && is_digit(chars_reg[5]) && is_digit(chars_reg[6])
                    && is_digit(chars_reg[8]) && is_digit(chars_reg[9]);

    assign rec.y3 = chars_reg[0][3:0];
    assign rec.y2 = chars_reg[1][3:0];
    assign rec.y1 = chars_reg[2][3:0];
    assign rec.y0 = chars_reg[3][3:0];
    assign rec.m1 = chars_reg[5][3:0];
    assign rec.m0 = chars_reg[6][3:0];
    assign rec.d1 = chars_reg[8][3:0];
    assign rec.d0 = chars_reg[9][3:0];

    assign low_zero  = (rec.y1 == 4'd0) && (rec.y0 == 4'd0);
    assign zero_year = low_zero && (rec.y3 == 4'd0) && (rec.y2 == 4'd0);
    // Century years are leap only when the century is a multiple of four.
    assign leap      = low_zero ? div4(rec.y3, rec.y2) : div4(rec.y1, rec.y0);
    assign month     = two_digits(rec.m1, rec.m0);
    assign day       = two_digits(rec.d1, rec.d0);
    assign dim       = month_days(month, leap);

    assign rec.ok = shape_ok && digits_ok && !zero_year
                 && (month >= 7'd1) && (month <= 7'd12)
                 && (day >= 7'd1) && (day <= {2'b00, dim});

    assign push = in_fire && close_line;

endmodule
`default_nettype wire

// ----- rtl/idlr_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idlr_queue: two-entry line record queue
// Decouples the line classifier from the result emitter.
// ----------------------------------------------------------------------------
module idlr_queue import idlr_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire line_rec_t push_rec,
    input  wire logic      pop,
    output logic           full,
    output logic           nempty,
    output line_rec_t      head
);

    line_rec_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign nempty = (count_reg != 2'd0);
    assign head   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/idlr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idlr_back: result emitter
// Walks the head record into a registered output stage, one character per
// cycle unless stalled: DD-MM-YYYY for a valid date, one marker otherwise.
// ----------------------------------------------------------------------------
module idlr_back import idlr_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       nempty,
    input  wire line_rec_t  head,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic [0:0]      m_tuser,
    output logic            m_tlast
);

    logic [3:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       user_reg, user_next;
    logic       last_reg, last_next;

    logic       load;
    logic       at_end;
    logic [3:0] digit;
    logic       is_dash;

    assign load   = nempty && (!valid_reg || m_tready);
    assign at_end = !head.ok || (pos_reg == POS_LAST);
    assign pop    = load && at_end;

    always_comb begin
        digit   = 4'd0;
        is_dash = 1'b0;
        unique case (pos_reg)
            4'd0:    digit = head.d1;
            4'd1:    digit = head.d0;
            4'd2:    is_dash = 1'b1;
            4'd3:    digit = head.m1;
            4'd4:    digit = head.m0;
            4'd5:    is_dash = 1'b1;
            4'd6:    digit = head.y3;
            4'd7:    digit = head.y2;
            4'd8:    digit = head.y1;
            4'd9:    digit = head.y0;
            default: digit = 4'd0;
        endcase
    end

    always_comb begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            user_next  = head.ok;
            last_next  = at_end;
            if (!head.ok) begin
                char_next = 8'd0;
            end else if (is_dash) begin
                char_next = CHAR_DASH;
            end else begin
                char_next = CHAR_ZERO | {4'd0, digit};
            end
            pos_next = at_end ? 4'd0 : pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
        char_reg <= char_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = char_reg;
    assign m_tuser[0] = user_reg;
    assign m_tlast    = last_reg;

endmodule
`default_nettype wire

// ----- rtl/iso_date_line_reformatter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iso_date_line_reformatter: YYYY-MM-DD lines to DD-MM-YYYY characters
// Accepts one character per cycle while the queue has room; a closed line
// becomes ten date results or a single invalid result.
// ----------------------------------------------------------------------------
// Throughput: one character in and one result out per cycle, unless stalled.
// Path: the closing request writes the line record into the queue, and the
//   back end then registers the first result into the output stage.
// The input stalls only while both line record queue slots are taken.
// Reset (aresetn low, synchronous) clears the line length, overflow flag,
// queue and output stage; the character store itself is not cleared.
module iso_date_line_reformatter import idlr_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_code
    input  wire logic [0:0] s_tuser,   // [0] end_of_input
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic [0:0]      m_tuser,   // [0] date_valid
    output logic            m_tlast
);

    logic      in_fire;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_nempty;
    line_rec_t push_rec;
    line_rec_t head_rec;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    idlr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .char_code    (s_tdata),
        .end_of_input (s_tuser[0]),
        .push         (push),
        .rec          (push_rec)
    );

    idlr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (q_full),
        .nempty   (q_nempty),
        .head     (head_rec)
    );

    idlr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .nempty   (q_nempty),
        .head     (head_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- rtl/idlr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idlr_checker: port-level checks of the date line reformatter
// Watches the result channel for reset behavior, stalls and result shape.
// ----------------------------------------------------------------------------
module idlr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [0:0] m_tuser,
    input wire logic       m_tlast
);

    // Nothing is offered in the cycle after a reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // An invalid line gives exactly one zero result that closes the line.
    a_invalid_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'd0))
        else $error("malformed invalid result");

    a_valid_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            ((m_tdata >= 8'd48) && (m_tdata <= 8'd57)) || (m_tdata == 8'd45))
        else $error("date result is not a digit or dash");

endmodule

bind iso_date_line_reformatter idlr_checker u_idlr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for iso_date_line_reformatter
// Feeds character lines (dates in and out of the calendar, noise, carriage
// returns, end-of-input marks, lines past capacity) under varying idle and
// stall patterns, and checks every output request against a date predictor.
// ----------------------------------------------------------------------------
module tb;
    import idlr_pkg::*;

    // How a stimulus row is checked: by the predictor, or against a result typed in here.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_INVALID,
        CHK_SILENT
    } row_check_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        row_check_t check;
    } char_row_t;

    typedef struct {
        char_row_t row;
        int        phase;
    } stim_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       ok;
        logic       fin;
    } date_out_t;

    localparam int REPORT_CAP = 50;
    localparam int PHASE_ITEMS = 100;
    localparam int IDLE_PCT [4] = '{0, 51, 0, 24};
    localparam int STALL_PCT [4] = '{0, 0, 51, 24};
    localparam int YEAR_PICKS [11] = '{0, 1, 4, 100, 400, 1900, 2000, 2023, 2024, 2100, 9999};

    localparam char_row_t DIRECTED_ROWS [0:21] = '{
        '{CHAR_NL,   1'b0, CHK_INVALID},
        '{8'h00,     1'b1, CHK_SILENT},
        '{"2",       1'b0, CHK_PREDICT},
        '{"0",       1'b0, CHK_PREDICT},
        '{"2",       1'b0, CHK_PREDICT},
        '{"4",       1'b0, CHK_PREDICT},
        '{CHAR_DASH, 1'b0, CHK_PREDICT},
        '{"0",       1'b0, CHK_PREDICT},
        '{"2",       1'b0, CHK_PREDICT},
        '{CHAR_DASH, 1'b0, CHK_PREDICT},
        '{"2",       1'b0, CHK_PREDICT},
        '{"9",       1'b0, CHK_PREDICT},
        '{CHAR_CR,   1'b0, CHK_PREDICT},
        '{8'hFF,     1'b1, CHK_PREDICT},
        '{8'h00,     1'b0, CHK_PREDICT},
        '{8'hFF,     1'b0, CHK_PREDICT},
        '{CHAR_NL,   1'b0, CHK_INVALID},
        '{CHAR_CR,   1'b0, CHK_PREDICT},
        '{CHAR_CR,   1'b0, CHK_PREDICT},
        '{CHAR_NL,   1'b0, CHK_INVALID},
        '{"A",       1'b0, CHK_PREDICT},
        '{8'h00,     1'b1, CHK_INVALID}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [0:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    // Predictor state: the kept head of the line, its length and the overflow flag.
    logic [7:0]       line_buf [KEPT_CHARS];
    logic [LEN_W-1:0] line_len;
    logic             line_ovf;

    stim_t     stim_q [$];
    date_out_t date_q [$];
    int        mismatches;
    int        cur_phase;

    iso_date_line_reformatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_CAP) begin
            $display("tb: %0t mismatch: %s", $time, what);
        end
    endtask

    function automatic bit dec_field(input int start, input int n, output int val);
        int acc;
        acc = 0;
        val = 0;
        for (int i = 0; i < n; i++) begin
            if (line_buf[start + i] < CHAR_ZERO || line_buf[start + i] > CHAR_NINE) begin
                return 1'b0;
            end
            acc = acc * 10 + int'(line_buf[start + i] - CHAR_ZERO);
        end
        val = acc;
        return 1'b1;
    endfunction

    task automatic close_line(output date_out_t outs [$]);
        int    len;
        int    yr;
        int    mo;
        int    dy;
        int    dim;
        bit    ok;
        bit    leap;
        string txt;
        outs = {};
        yr = 0;
        mo = 0;
        dy = 0;
        len = int'(line_len);
        ok = !line_ovf;
        if (ok && len > 0 && len <= KEPT_CHARS && line_buf[len - 1] == CHAR_CR) begin
            len--;
        end
        if (len != 10) begin
            ok = 1'b0;
        end
        if (ok && (line_buf[4] != CHAR_DASH || line_buf[7] != CHAR_DASH)) begin
            ok = 1'b0;
        end
        if (ok) begin
            ok = dec_field(0, 4, yr) && dec_field(5, 2, mo) && dec_field(8, 2, dy);
        end
        if (ok && (yr < 1 || mo < 1 || mo > 12)) begin
            ok = 1'b0;
        end
        if (ok) begin
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            case (mo)
                2: begin
                    dim = leap ? 29 : 28;
                end
                4, 6, 9, 11: begin
                    dim = 30;
                end
                default: begin
                    dim = 31;
                end
            endcase
            if (dy < 1 || dy > dim) begin
                ok = 1'b0;
            end
        end
        line_len = '0;
        line_ovf = 1'b0;
        if (!ok) begin
            outs.push_back('{8'h00, 1'b0, 1'b1});
        end else begin
            txt = $sformatf("%02d-%02d-%04d", dy, mo, yr);
            for (int i = 0; i < 10; i++) begin
                outs.push_back('{txt[i], 1'b1, i == 9});
            end
        end
    endtask

    task automatic take_char(input logic [7:0] ch, input logic eoi, output date_out_t outs [$]);
        outs = {};
        if (eoi) begin
            // An end mark on an empty line leaves everything as it is.
            if (line_len != 0 || line_ovf) begin
                close_line(outs);
            end
        end else if (ch == CHAR_NL) begin
            close_line(outs);
        end else if (!line_ovf) begin
            if (int'(line_len) + 1 >= LINE_CAPACITY) begin
                line_ovf = 1'b1;
            end else begin
                if (line_len < KEPT_CHARS) begin
                    line_buf[line_len] = ch;
                end
                if (line_len != LEN_MAX) begin
                    line_len++;
                end
            end
        end
    endtask

    task automatic add_item(input logic [7:0] ch, input logic eoi, input int ph);
        stim_t it;
        it.row = '{ch, eoi, CHK_PREDICT};
        it.phase = ph;
        stim_q.push_back(it);
    endtask

    // One random line; most are date-shaped with random fields and a few defects.
    task automatic add_random_line(input int ph, input int long_len);
        logic [7:0] txt [$];
        logic [7:0] c;
        string      s;
        int         pick;
        int         yr;
        int         mo;
        int         dy;
        int         n;
        pick = $urandom_range(0, 99);
        if (long_len > 0) begin
            repeat (long_len) begin
                c = 8'($urandom_range(0, 255));
                txt.push_back((c == CHAR_NL) ? 8'h78 : c);
            end
        end else if (pick < 65) begin
            yr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 9999)
                                             : YEAR_PICKS[$urandom_range(0, 10)];
            mo = $urandom_range(0, 13);
            dy = $urandom_range(0, 32);
            if ($urandom_range(0, 4) == 0) begin
                mo = 2;
                dy = $urandom_range(28, 30);
            end
            s = $sformatf("%04d-%02d-%02d", yr, mo, dy);
            for (int i = 0; i < s.len(); i++) begin
                txt.push_back(s[i]);
            end
            n = $urandom_range(0, 19);
            if (n == 0) begin
                txt[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
            end else if (n == 1) begin
                txt.insert($urandom_range(0, 10), 8'($urandom_range(0, 255)));
            end else if (n == 2) begin
                txt.delete($urandom_range(0, 9));
            end
            if ($urandom_range(0, 3) == 0) begin
                txt.push_back(CHAR_CR);
            end
        end else if (pick < 88) begin
            n = $urandom_range(0, 13);
            repeat (n) txt.push_back(8'($urandom_range(0, 255)));
        end
        foreach (txt[i]) begin
            add_item(txt[i], 1'b0, ph);
        end
        if ($urandom_range(0, 4) == 0) begin
            add_item(8'($urandom_range(0, 255)), 1'b1, ph);
        end else begin
            add_item(CHAR_NL, 1'b0, ph);
        end
    endtask

    // The receiver's ready follows the stall rate of the phase now being driven.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= STALL_PCT[cur_phase]);
    end

    always @(posedge aclk) begin
        date_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (date_q.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing expected", m_tdata));
            end else begin
                want = date_q.pop_front();
                if (m_tdata !== want.ch) begin
                    flag_mismatch($sformatf("out_char %h, expected %h", m_tdata, want.ch));
                end
                if (m_tuser[0] !== want.ok) begin
                    flag_mismatch($sformatf("date_valid %b, expected %b", m_tuser[0], want.ok));
                end
                if (m_tlast !== want.fin) begin
                    flag_mismatch($sformatf("last %b, expected %b", m_tlast, want.fin));
                end
            end
        end
    end

    initial begin
        #200000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        stim_t     it;
        date_out_t outs [$];
        int        idx;
        bit        holding;
        int        base;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatches = 0;
        cur_phase = 0;
        line_len = '0;
        line_ovf = 1'b0;

        foreach (DIRECTED_ROWS[i]) begin
            it.row = DIRECTED_ROWS[i];
            it.phase = 0;
            stim_q.push_back(it);
        end
        // A line at full length fits; one longer sets the overflow flag.
        for (int ph = 0; ph < 4; ph++) begin
            base = stim_q.size();
            if (ph == 1) begin
                add_random_line(ph, $urandom_range(64, 66));
            end else if (ph == 3) begin
                add_random_line(ph, LINE_CAPACITY - 1);
            end
            while (stim_q.size() - base < PHASE_ITEMS) begin
                add_random_line(ph, 0);
            end
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        idx = 0;
        holding = 1'b0;
        while (idx < stim_q.size()) begin
            @(negedge aclk);
            it = stim_q[idx];
            cur_phase = it.phase;
            if (!holding) begin
                if ($urandom_range(0, 99) < IDLE_PCT[it.phase]) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= it.row.ch;
                    s_tuser <= it.row.eoi;
                    holding = 1'b1;
                end
            end
            @(posedge aclk);
            if (holding && s_tready) begin
                take_char(it.row.ch, it.row.eoi, outs);
                if (it.row.check == CHK_INVALID) begin
                    outs = '{'{8'h00, 1'b0, 1'b1}};
                end else if (it.row.check == CHK_SILENT) begin
                    outs = {};
                end
                foreach (outs[i]) begin
                    date_q.push_back(outs[i]);
                end
                holding = 1'b0;
                idx++;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (date_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && date_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
